>>> hdl/qpr_pkg.sv
// Shared types and constants for the quaternion point rotation core.
// No dependencies; every other file but qpr_mul refers to this package by scoped names.
package qpr_pkg;

    // Fraction bits of every raw value, and the rounding constant that goes with it
    localparam int unsigned      FRAC_BITS  = 16;
    localparam logic [FRAC_BITS:0]   ONE_RAW    = (FRAC_BITS + 1)'(1 << FRAC_BITS);
    localparam logic [FRAC_BITS-1:0] ROUND_HALF = FRAC_BITS'(1 << (FRAC_BITS - 1));

    // Intermediate words wrap at this width
    localparam int unsigned WORD_W = 64;

    // Register stages from input handshake to output register
    localparam int unsigned PIPE_DEPTH = 9;

    // Configuration register indexes
    localparam int unsigned      CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAT_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAT_W = 2'd3;

    // Load enables of the three register steps of one arithmetic section
    typedef struct packed {
        logic part;   // partial products
        logic prod;   // combined products
        logic res;    // rounded sums
    } t_step_en;

endpackage

>>> hdl/qpr_mul.sv
// Two-step signed multiplier: the wide operand is split in halves, partial
// products are registered, then combined. Uses no package items.
module qpr_mul #(
    parameter int A_W = 18,
    parameter int B_W = 36,
    parameter int P_W = 56
) (
    input  logic                  i_clk,
    input  logic                  i_en_part,
    input  logic                  i_en_prod,
    input  logic signed [A_W-1:0] i_a,
    input  logic signed [B_W-1:0] i_b,
    output logic signed [P_W-1:0] o_p
);

    localparam int LO_W   = B_W / 2;
    localparam int HI_W   = B_W - LO_W;
    localparam int FULL_W = A_W + B_W;
    localparam int SUM_W  = (P_W > FULL_W) ? P_W : FULL_W;

    logic signed [A_W+LO_W:0]   r_lo, n_lo;
    logic signed [A_W+HI_W-1:0] r_hi, n_hi;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [P_W-1:0]      r_p;

    always_comb begin
        // low half of b is unsigned, high half carries the sign
        n_lo  = i_a * $signed({1'b0, i_b[LO_W-1:0]});
        n_hi  = i_a * $signed(i_b[B_W-1:LO_W]);
        n_sum = (SUM_W'(r_hi) <<< LO_W) + SUM_W'(r_lo);
    end

    always_ff @(posedge i_clk) begin
        if (i_en_part) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (i_en_prod) begin
            r_p <= n_sum[P_W-1:0];
        end
    end

    assign o_p = r_p;

endmodule

>>> hdl/qpr_qv.sv
// First Hamilton product r = q * (v, 1), rounded to 16 fraction bits.
// Depends on qpr_pkg and qpr_mul.
module qpr_qv #(
    parameter int QW  = 18,
    parameter int CW  = 32,
    parameter int S_W = 52
) (
    input  logic                                     i_clk,
    input  qpr_pkg::t_step_en                        i_en,
    input  logic signed [QW-1:0]                     i_qx,
    input  logic signed [QW-1:0]                     i_qy,
    input  logic signed [QW-1:0]                     i_qz,
    input  logic signed [QW-1:0]                     i_qw,
    input  logic signed [CW-1:0]                     i_vx,
    input  logic signed [CW-1:0]                     i_vy,
    input  logic signed [CW-1:0]                     i_vz,
    output logic signed [S_W-qpr_pkg::FRAC_BITS-1:0] o_rx,
    output logic signed [S_W-qpr_pkg::FRAC_BITS-1:0] o_ry,
    output logic signed [S_W-qpr_pkg::FRAC_BITS-1:0] o_rz,
    output logic signed [S_W-qpr_pkg::FRAC_BITS-1:0] o_rw
);

    localparam int FRAC = qpr_pkg::FRAC_BITS;
    localparam int NMUL = 12;

    logic signed [QW-1:0]  m_a [NMUL];
    logic signed [CW-1:0]  m_b [NMUL];
    logic signed [S_W-1:0] m_p [NMUL];
    logic signed [S_W-1:0] c_half, sh_x, sh_y, sh_z, sh_w;
    logic signed [S_W-1:0] n_sx, n_sy, n_sz, n_sw;
    logic signed [S_W-FRAC-1:0] r_rx, r_ry, r_rz, r_rw;

    always_comb begin
        m_a[0]  = i_qw; m_b[0]  = i_vx;
        m_a[1]  = i_qy; m_b[1]  = i_vz;
        m_a[2]  = i_qz; m_b[2]  = i_vy;
        m_a[3]  = i_qw; m_b[3]  = i_vy;
        m_a[4]  = i_qz; m_b[4]  = i_vx;
        m_a[5]  = i_qx; m_b[5]  = i_vz;
        m_a[6]  = i_qw; m_b[6]  = i_vz;
        m_a[7]  = i_qx; m_b[7]  = i_vy;
        m_a[8]  = i_qy; m_b[8]  = i_vx;
        m_a[9]  = i_qx; m_b[9]  = i_vx;
        m_a[10] = i_qy; m_b[10] = i_vy;
        m_a[11] = i_qz; m_b[11] = i_vz;
    end

    for (genvar g = 0; g < NMUL; g++) begin : g_mul
        qpr_mul #(.A_W(QW), .B_W(CW), .P_W(S_W)) u_mul (
            .i_clk     (i_clk),
            .i_en_part (i_en.part),
            .i_en_prod (i_en.prod),
            .i_a       (m_a[g]),
            .i_b       (m_b[g]),
            .o_p       (m_p[g])
        );
    end

    always_comb begin
        c_half = S_W'(qpr_pkg::ROUND_HALF);
        // the scalar 1 of the point turns q terms into plain shifts
        sh_x   = S_W'(i_qx) <<< FRAC;
        sh_y   = S_W'(i_qy) <<< FRAC;
        sh_z   = S_W'(i_qz) <<< FRAC;
        sh_w   = S_W'(i_qw) <<< FRAC;
        n_sx   = m_p[0] + sh_x + m_p[1] - m_p[2] + c_half;
        n_sy   = m_p[3] + sh_y + m_p[4] - m_p[5] + c_half;
        n_sz   = m_p[6] + sh_z + m_p[7] - m_p[8] + c_half;
        n_sw   = sh_w - (m_p[9] + m_p[10] + m_p[11]) + c_half;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.res) begin
            r_rx <= n_sx[S_W-1:FRAC];
            r_ry <= n_sy[S_W-1:FRAC];
            r_rz <= n_sz[S_W-1:FRAC];
            r_rw <= n_sw[S_W-1:FRAC];
        end
    end

    assign o_rx = r_rx;
    assign o_ry = r_ry;
    assign o_rz = r_rz;
    assign o_rw = r_rw;

endmodule

>>> hdl/qpr_rc.sv
// Second Hamilton product t = r * conj(q), rounded to 16 fraction bits.
// Depends on qpr_pkg and qpr_mul.
module qpr_rc #(
    parameter int QW  = 18,
    parameter int RW  = 36,
    parameter int S_W = 56
) (
    input  logic                                     i_clk,
    input  qpr_pkg::t_step_en                        i_en,
    input  logic signed [QW-1:0]                     i_qx,
    input  logic signed [QW-1:0]                     i_qy,
    input  logic signed [QW-1:0]                     i_qz,
    input  logic signed [QW-1:0]                     i_qw,
    input  logic signed [RW-1:0]                     i_rx,
    input  logic signed [RW-1:0]                     i_ry,
    input  logic signed [RW-1:0]                     i_rz,
    input  logic signed [RW-1:0]                     i_rw,
    output logic signed [S_W-qpr_pkg::FRAC_BITS-1:0] o_tx,
    output logic signed [S_W-qpr_pkg::FRAC_BITS-1:0] o_ty,
    output logic signed [S_W-qpr_pkg::FRAC_BITS-1:0] o_tz,
    output logic signed [S_W-qpr_pkg::FRAC_BITS-1:0] o_tw
);

    localparam int FRAC = qpr_pkg::FRAC_BITS;
    localparam int NMUL = 16;

    logic signed [QW-1:0]  m_a [NMUL];
    logic signed [RW-1:0]  m_b [NMUL];
    logic signed [S_W-1:0] m_p [NMUL];
    logic signed [S_W-1:0] c_half, n_sx, n_sy, n_sz, n_sw;
    logic signed [S_W-FRAC-1:0] r_tx, r_ty, r_tz, r_tw;

    always_comb begin
        m_a[0]  = i_qw; m_b[0]  = i_rx;
        m_a[1]  = i_qx; m_b[1]  = i_rw;
        m_a[2]  = i_qz; m_b[2]  = i_ry;
        m_a[3]  = i_qy; m_b[3]  = i_rz;
        m_a[4]  = i_qw; m_b[4]  = i_ry;
        m_a[5]  = i_qy; m_b[5]  = i_rw;
        m_a[6]  = i_qx; m_b[6]  = i_rz;
        m_a[7]  = i_qz; m_b[7]  = i_rx;
        m_a[8]  = i_qw; m_b[8]  = i_rz;
        m_a[9]  = i_qz; m_b[9]  = i_rw;
        m_a[10] = i_qy; m_b[10] = i_rx;
        m_a[11] = i_qx; m_b[11] = i_ry;
        m_a[12] = i_qw; m_b[12] = i_rw;
        m_a[13] = i_qx; m_b[13] = i_rx;
        m_a[14] = i_qy; m_b[14] = i_ry;
        m_a[15] = i_qz; m_b[15] = i_rz;
    end

    for (genvar g = 0; g < NMUL; g++) begin : g_mul
        qpr_mul #(.A_W(QW), .B_W(RW), .P_W(S_W)) u_mul (
            .i_clk     (i_clk),
            .i_en_part (i_en.part),
            .i_en_prod (i_en.prod),
            .i_a       (m_a[g]),
            .i_b       (m_b[g]),
            .o_p       (m_p[g])
        );
    end

    always_comb begin
        c_half = S_W'(qpr_pkg::ROUND_HALF);
        n_sx   = m_p[0]  - m_p[1]  - m_p[2]  + m_p[3]  + c_half;
        n_sy   = m_p[4]  - m_p[5]  - m_p[6]  + m_p[7]  + c_half;
        n_sz   = m_p[8]  - m_p[9]  - m_p[10] + m_p[11] + c_half;
        n_sw   = m_p[12] + m_p[13] + m_p[14] + m_p[15] + c_half;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.res) begin
            r_tx <= n_sx[S_W-1:FRAC];
            r_ty <= n_sy[S_W-1:FRAC];
            r_tz <= n_sz[S_W-1:FRAC];
            r_tw <= n_sw[S_W-1:FRAC];
        end
    end

    assign o_tx = r_tx;
    assign o_ty = r_ty;
    assign o_tz = r_tz;
    assign o_tw = r_tw;

endmodule

>>> hdl/qpr_scale.sv
// Final scale of the vector part by the scalar part, rounding, saturation
// and the output register. Depends on qpr_pkg and qpr_mul.
module qpr_scale #(
    parameter int TW  = 40,
    parameter int CW  = 32,
    parameter int P_W = 64
) (
    input  logic                 i_clk,
    input  qpr_pkg::t_step_en    i_en,
    input  logic signed [TW-1:0] i_tx,
    input  logic signed [TW-1:0] i_ty,
    input  logic signed [TW-1:0] i_tz,
    input  logic signed [TW-1:0] i_tw,
    output logic [CW-1:0]        o_x,
    output logic [CW-1:0]        o_y,
    output logic [CW-1:0]        o_z,
    output logic                 o_sat
);

    localparam int FRAC = qpr_pkg::FRAC_BITS;
    localparam int Y_W  = P_W - FRAC;

    logic signed [TW-1:0]  m_b   [3];
    logic signed [P_W-1:0] m_p   [3];
    logic signed [P_W-1:0] n_rnd [3];
    logic [Y_W-1:0]        n_y   [3];
    logic [CW-1:0]         n_c   [3];
    logic [2:0]            n_clip;
    logic signed [P_W-1:0] c_half;
    logic [CW-1:0]         r_x, r_y, r_z;
    logic                  r_sat;

    assign c_half = P_W'(qpr_pkg::ROUND_HALF);
    assign m_b[0] = i_tx;
    assign m_b[1] = i_ty;
    assign m_b[2] = i_tz;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        qpr_mul #(.A_W(TW), .B_W(TW), .P_W(P_W)) u_mul (
            .i_clk     (i_clk),
            .i_en_part (i_en.part),
            .i_en_prod (i_en.prod),
            .i_a       (i_tw),
            .i_b       (m_b[g]),
            .o_p       (m_p[g])
        );

        assign n_rnd[g] = m_p[g] + c_half;
        assign n_y[g]   = n_rnd[g][P_W-1:FRAC];

        if (Y_W > CW) begin : g_clip
            // clip when the bits above the output sign disagree with it
            assign n_clip[g] = !((&n_y[g][Y_W-1:CW-1]) || !(|n_y[g][Y_W-1:CW-1]));
            assign n_c[g]    = n_clip[g] ? {n_y[g][Y_W-1], {(CW-1){~n_y[g][Y_W-1]}}}
                                         : n_y[g][CW-1:0];
        end else begin : g_fit
            assign n_clip[g] = 1'b0;
            assign n_c[g]    = CW'($signed(n_y[g]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.res) begin
            r_x   <= n_c[0];
            r_y   <= n_c[1];
            r_z   <= n_c[2];
            r_sat <= |n_clip;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_sat = r_sat;

endmodule

>>> hdl/quaternion_point_rotation_core.sv
// Quaternion point rotation core: top level with configuration registers,
// pipeline valid/ready control and the three arithmetic sections.
// Depends on qpr_pkg, qpr_mul, qpr_qv, qpr_rc and qpr_scale.
// Usage
//   Slave stream (i_s_axis_*) takes one point per item, master stream
//   (o_m_axis_*) returns one rotated point per item, in order.
//   The config channel (i_cfg_*) writes quat_x, quat_y, quat_z, quat_w at
//   indexes 0..3; o_cfg_ready is always high. Write only while no item is
//   in flight; the registers feed the first two sections directly.
// Pipeline and throughput
//   Nine register stages: three sections, each a two-step split multiplier
//   and a rounding step. One item per cycle while the output is not held:
//   every stage takes a new item each cycle.
// Reset
//   Synchronous, active low. All stage valid bits clear, the quaternion
//   returns to identity (w = 1.0, x = y = z = 0).
// Stall
//   A full stage holds while its successor is full and held; a stalled output
//   holds its data while empty upstream stages keep taking items.
module quaternion_point_rotation_core #(
    parameter int COORD_WIDTH = 32,
    parameter int QUAT_WIDTH  = 18
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // fields from bit 0: point_x, point_y, point_z, zero pad to bytes
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    // master stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // fields from bit 0: rotated_x, rotated_y, rotated_z, zero pad to bytes
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    // fields from bit 0: saturated_flag
    output logic                              o_m_axis_tuser,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [qpr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [QUAT_WIDTH-1:0]             i_cfg_data
);

    localparam int TDATA_W = ((3*COORD_WIDTH+7)/8)*8;
    localparam int FRAC    = qpr_pkg::FRAC_BITS;
    localparam int WORD    = qpr_pkg::WORD_W;
    localparam int DEPTH   = qpr_pkg::PIPE_DEPTH;

    // Sum widths of each section: exact where they fit, wrap at the word
    // width otherwise
    localparam int S1_W = (QUAT_WIDTH + COORD_WIDTH + 2 > WORD) ? WORD
                                                               : QUAT_WIDTH + COORD_WIDTH + 2;
    localparam int R_W  = S1_W - FRAC;
    localparam int S2_W = (QUAT_WIDTH + R_W + 2 > WORD) ? WORD : QUAT_WIDTH + R_W + 2;
    localparam int T_W  = S2_W - FRAC;
    localparam int P3_W = (2 * T_W + 1 > WORD) ? WORD : 2 * T_W + 1;

    // Configuration registers
    logic signed [QUAT_WIDTH-1:0] r_qx, r_qy, r_qz, r_qw;

    // Pipeline control
    logic [DEPTH-1:0] r_vld, n_vld, adv;

    // Section data
    logic signed [R_W-1:0] rx, ry, rz, rw;
    logic signed [T_W-1:0] tx, ty, tz, tw;
    logic [COORD_WIDTH-1:0] out_x, out_y, out_z;
    logic                   out_sat;

    qpr_pkg::t_step_en en_qv, en_rc, en_sc;

    // Configuration writes: no back pressure, unknown indexes drop
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx <= '0;
            r_qy <= '0;
            r_qz <= '0;
            r_qw <= QUAT_WIDTH'(qpr_pkg::ONE_RAW);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                qpr_pkg::CFG_QUAT_X: r_qx <= i_cfg_data;
                qpr_pkg::CFG_QUAT_Y: r_qy <= i_cfg_data;
                qpr_pkg::CFG_QUAT_Z: r_qz <= i_cfg_data;
                qpr_pkg::CFG_QUAT_W: r_qw <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage advances when it is empty or its successor advances
    always_comb begin
        adv[DEPTH-1] = !r_vld[DEPTH-1] || i_m_axis_tready;
        for (int k = DEPTH - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            if (k == 0) begin
                n_vld[k] = adv[k] ? i_s_axis_tvalid : r_vld[k];
            end else begin
                n_vld[k] = adv[k] ? r_vld[k-1] : r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_s_axis_tready = adv[0];
    assign o_m_axis_tvalid = r_vld[DEPTH-1];

    // Stage enables: three per section
    assign en_qv = '{part: adv[0], prod: adv[1], res: adv[2]};
    assign en_rc = '{part: adv[3], prod: adv[4], res: adv[5]};
    assign en_sc = '{part: adv[6], prod: adv[7], res: adv[8]};

    // r = q * (v, 1)
    qpr_qv #(.QW(QUAT_WIDTH), .CW(COORD_WIDTH), .S_W(S1_W)) u_qv (
        .i_clk (i_clk),
        .i_en  (en_qv),
        .i_qx  (r_qx),
        .i_qy  (r_qy),
        .i_qz  (r_qz),
        .i_qw  (r_qw),
        .i_vx  (i_s_axis_tdata[COORD_WIDTH-1:0]),
        .i_vy  (i_s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .i_vz  (i_s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]),
        .o_rx  (rx),
        .o_ry  (ry),
        .o_rz  (rz),
        .o_rw  (rw)
    );

    // t = r * conj(q)
    qpr_rc #(.QW(QUAT_WIDTH), .RW(R_W), .S_W(S2_W)) u_rc (
        .i_clk (i_clk),
        .i_en  (en_rc),
        .i_qx  (r_qx),
        .i_qy  (r_qy),
        .i_qz  (r_qz),
        .i_qw  (r_qw),
        .i_rx  (rx),
        .i_ry  (ry),
        .i_rz  (rz),
        .i_rw  (rw),
        .o_tx  (tx),
        .o_ty  (ty),
        .o_tz  (tz),
        .o_tw  (tw)
    );

    // vector part times scalar part, then clip to the coordinate range
    qpr_scale #(.TW(T_W), .CW(COORD_WIDTH), .P_W(P3_W)) u_scale (
        .i_clk (i_clk),
        .i_en  (en_sc),
        .i_tx  (tx),
        .i_ty  (ty),
        .i_tz  (tz),
        .i_tw  (tw),
        .o_x   (out_x),
        .o_y   (out_y),
        .o_z   (out_z),
        .o_sat (out_sat)
    );

    assign o_m_axis_tdata = TDATA_W'({out_z, out_y, out_x});
    assign o_m_axis_tuser = out_sat;

endmodule

>>> hdl/qpr_checker.sv
// Port-level checks for the quaternion point rotation core, bound to the
// top level below. Depends on qpr_pkg.
module qpr_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_axis_tvalid,
    input logic                               o_s_axis_tready,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [((3*COORD_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    input logic                               o_m_axis_tuser
);

    localparam int DEPTH = qpr_pkg::PIPE_DEPTH;
    localparam int CNT_W = $clog2(DEPTH + 2);
    localparam logic [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   s_acc, m_acc;
    logic [COORD_WIDTH-1:0] ox, oy, oz;

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign m_acc = o_m_axis_tvalid && i_m_axis_tready;
    assign ox    = o_m_axis_tdata[COORD_WIDTH-1:0];
    assign oy    = o_m_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign oz    = o_m_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

    always_comb begin
        n_cnt = r_cnt;
        if (s_acc && !m_acc) begin
            n_cnt = r_cnt + 1'b1;
        end else if (m_acc && !s_acc) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // items taken but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // no result without a point behind it, never more in flight than stages
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= CNT_W'(DEPTH)) && (!o_m_axis_tvalid || (r_cnt != '0)))
        else $error("item count out of range");

    // input is refused only when the output is held
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input refused without output stall");

    // a clip flag comes with at least one coordinate at a range limit
    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
            (ox == C_MAX) || (ox == C_MIN) || (oy == C_MAX) || (oy == C_MIN) ||
            (oz == C_MAX) || (oz == C_MIN))
        else $error("clip flag without a limit value");

endmodule

bind quaternion_point_rotation_core qpr_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_qpr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
